// ===== design/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared constants, codes and types for the ray against box face unit.
// ----------------------------------------------------------------------------
package rbf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TW        = 32 + FRAC_BITS;
   localparam int PROD_W    = FRAC_BITS + 64;
   localparam int OFF_W     = 64 - FRAC_BITS;
   localparam int SQ_STEPS  = 31;
   localparam int TEX_STEPS = 17;
   localparam int REQ_W     = 192;
   localparam int RSP_W     = 168;
   localparam int RSP_USER_W = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [31:0] BOX_MIN_RESET = 32'h0000_0000;
   localparam logic [31:0] BOX_MAX_RESET = 32'h0001_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Z = 3'd5;

   localparam logic [2:0] FACE_NONE  = 3'd0;
   localparam logic [2:0] FACE_POS_X = 3'd1;
   localparam logic [2:0] FACE_NEG_X = 3'd2;
   localparam logic [2:0] FACE_POS_Y = 3'd3;
   localparam logic [2:0] FACE_NEG_Y = 3'd4;
   localparam logic [2:0] FACE_POS_Z = 3'd5;
   localparam logic [2:0] FACE_NEG_Z = 3'd6;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic [2:0][31:0] o;
      logic [2:0][31:0] d;
      logic [2:0][31:0] ad;
      logic [2:0][31:0] a;
      logic             unb;
      logic [2:0]       cand;
   } ray_type;

   typedef struct packed {
      logic [31:0] r;
      logic [16:0] nq;
      logic [31:0] size;
      logic        flat;
   } tex_type;

   typedef struct packed {
      logic             hit;
      logic [2:0]       code;
      logic [2:0][31:0] pt;
      logic             sat;
      logic [61:0]      x;
      logic [30:0]      root;
      logic [32:0]      rem;
      tex_type          tu;
      tex_type          tv;
   } tail_type;

   function automatic logic [2:0] face_of(input logic [1:0] ax, input logic upper);
      logic [2:0] f;
      case (ax)
         AXIS_X:  f = upper ? FACE_POS_X : FACE_NEG_X;
         AXIS_Y:  f = upper ? FACE_POS_Y : FACE_NEG_Y;
         AXIS_Z:  f = upper ? FACE_POS_Z : FACE_NEG_Z;
         default: f = FACE_NONE;
      endcase
      return f;
   endfunction

   function automatic logic [1:0] tex_u_axis(input logic [1:0] ax);
      logic [1:0] b;
      case (ax)
         AXIS_X:  b = AXIS_Z;
         AXIS_Y:  b = AXIS_X;
         default: b = AXIS_X;
      endcase
      return b;
   endfunction

   function automatic logic [1:0] tex_v_axis(input logic [1:0] ax);
      logic [1:0] c;
      case (ax)
         AXIS_X:  c = AXIS_Y;
         AXIS_Y:  c = AXIS_Z;
         default: c = AXIS_Y;
      endcase
      return c;
   endfunction

endpackage

// ===== design/ray_box_face_intersect_top.sv =====
// ----------------------------------------------------------------------------
// ray_box_face_intersect_top
// Ray against axis-aligned box, first accepted face, fully pipelined.
//
// req_* carries one ray per word: origins and directions in tdata, the
// unbounded flag in tuser. rsp_* returns one result word per ray: point,
// distance and texture coordinates in tdata, hit and face code in tuser.
// csr_* writes the six box bounds by index; it is always ready, and it must be
// written only while no ray is in flight, which the block itself does not enforce.
// Throughput: one ray per cycle unless back-pressure fills the skid register.
// From accept to the result word a ray passes the bit-per-stage ray parameter
// divider (32 + FRAC_BITS stages) and the 31-stage square root.
// Reset clears all valid bits and loads the default unit box.
// When rsp_tready is low, a skid register takes one more word, then the whole
// pipeline holds in place and req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_box_face_intersect_top
   import rbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [REQ_W-1:0]      req_tdata,
   // unbounded_ray
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // point_x, point_y, point_z, hit_distance, tex_u, tex_v, zero pad
   output logic [RSP_W-1:0]      rsp_tdata,
   // hit, face_code
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_data
);

   logic [2:0][31:0] box_min_ff, box_max_ff;
   logic             en;
   logic             out_v_ff, sk_v_ff;
   logic [RSP_W+RSP_USER_W-1:0] out_ff, sk_ff, fin_word;

   assign csr_ready  = 1'b1;
   assign en         = !sk_v_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_ff <= {3{BOX_MIN_RESET}};
         box_max_ff <= {3{BOX_MAX_RESET}};
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_X: box_min_ff[0] <= csr_data;
            CSR_MIN_Y: box_min_ff[1] <= csr_data;
            CSR_MIN_Z: box_min_ff[2] <= csr_data;
            CSR_MAX_X: box_max_ff[0] <= csr_data;
            CSR_MAX_Y: box_max_ff[1] <= csr_data;
            CSR_MAX_Z: box_max_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   logic             s0_v_ff;
   logic [2:0][31:0] s0_o_ff, s0_d_ff;
   logic             s0_unb_ff;

   always_ff @(posedge clock) begin
      if (reset) s0_v_ff <= 1'b0;
      else if (en) s0_v_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_o_ff   <= req_tdata[95:0];
         s0_d_ff   <= req_tdata[191:96];
         s0_unb_ff <= req_tuser[0];
      end
   end

   // candidate faces and divider operands
   logic [2:0][31:0]    div_r_ff  [TW+1];
   logic [2:0][TW-1:0]  div_nq_ff [TW+1];
   logic [2:0][31:0]    div_d_ff  [TW+1];
   ray_type             div_ray_ff [TW+1];
   logic                div_v_ff  [TW+1];
   ray_type             prep_in;
   logic [2:0][TW-1:0]  prep_nq_in;

   always_comb begin
      logic [31:0] plane;
      logic [32:0] diff;
      logic [32:0] adiff;
      logic        upper;
      prep_in.o   = s0_o_ff;
      prep_in.d   = s0_d_ff;
      prep_in.unb = s0_unb_ff;
      for (int ax = 0; ax < 3; ax++) begin
         upper = s0_d_ff[ax][31];
         plane = upper ? box_max_ff[ax] : box_min_ff[ax];
         diff  = {plane[31], plane} - {s0_o_ff[ax][31], s0_o_ff[ax]};
         adiff = diff[32] ? (33'd0 - diff) : diff;
         prep_in.cand[ax] = upper ? diff[32]
                                  : ((s0_d_ff[ax] != 32'd0) && !diff[32] && (diff != 33'd0));
         prep_in.a[ax]  = adiff[31:0];
         prep_in.ad[ax] = s0_d_ff[ax][31] ? (32'd0 - s0_d_ff[ax]) : s0_d_ff[ax];
         prep_nq_in[ax] = {adiff[31:0], {FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) div_v_ff[0] <= 1'b0;
      else if (en) div_v_ff[0] <= s0_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ray_ff[0] <= prep_in;
         div_r_ff[0]   <= '0;
         div_nq_ff[0]  <= prep_nq_in;
         div_d_ff[0]   <= prep_in.ad;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar i = 1; i <= TW; i++) begin : g_div
      logic [2:0][31:0]   r_in;
      logic [2:0][TW-1:0] nq_in;

      always_comb begin
         logic [32:0] rs;
         logic        ge;
         for (int ax = 0; ax < 3; ax++) begin
            rs = {div_r_ff[i-1][ax], div_nq_ff[i-1][ax][TW-1]};
            ge = rs >= {1'b0, div_d_ff[i-1][ax]};
            r_in[ax]  = ge ? 32'(rs - {1'b0, div_d_ff[i-1][ax]}) : rs[31:0];
            nq_in[ax] = {div_nq_ff[i-1][ax][TW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) div_v_ff[i] <= 1'b0;
         else if (en) div_v_ff[i] <= div_v_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ray_ff[i] <= div_ray_ff[i-1];
            div_r_ff[i]   <= r_in;
            div_nq_ff[i]  <= nq_in;
            div_d_ff[i]   <= div_d_ff[i-1];
         end
      end
   end

   // offsets on the other two axes, points, box check and squared reach check
   logic                          m1_v_ff, m2_v_ff, m3_v_ff, m4_v_ff, m5_v_ff;
   ray_type                       m1_ray_ff, m2_ray_ff, m3_ray_ff, m4_ray_ff, m5_ray_ff;
   logic [2:0][1:0][63:0]         m1_pl_ff;
   logic [2:0][1:0][FRAC_BITS+31:0] m1_ph_ff;
   logic [2:0][1:0][OFF_W-1:0]    m2_off_ff;
   logic [2:0][1:0]               m2_ovf_ff;
   logic [2:0][1:0][31:0]         m3_p_ff, m3_m_ff, m4_p_ff, m5_p_ff;
   logic [2:0]                    m3_ok_ff, m4_ok_ff, m5_acc_ff;
   logic [2:0][2:0][63:0]         m4_sq_ff;
   logic [2:0][63:0]              m4_len_ff;
   logic [2:0][65:0]              m5_sum_ff;

   logic [2:0][1:0][63:0]         m1_pl_in;
   logic [2:0][1:0][FRAC_BITS+31:0] m1_ph_in;
   logic [2:0][1:0][OFF_W-1:0]    m2_off_in;
   logic [2:0][1:0]               m2_ovf_in;
   logic [2:0][1:0][31:0]         m3_p_in, m3_m_in;
   logic [2:0][1:0]               m3_in_box;
   logic [2:0]                    m3_ok_in;
   logic [2:0][2:0][63:0]         m4_sq_in;
   logic [2:0][63:0]              m4_len_in;
   logic [2:0][65:0]              m5_sum_in;
   logic [2:0]                    m5_acc_in;

   for (genvar ax = 0; ax < 3; ax++) begin : g_ax
      for (genvar k = 0; k < 2; k++) begin : g_oth
         localparam int J = (ax + k + 1) % 3;
         logic [PROD_W-1:0] prod;
         logic signed [65:0] pv, mn, mx;

         assign m1_pl_in[ax][k] = div_nq_ff[TW][ax][31:0] * div_ray_ff[TW].ad[J];
         assign m1_ph_in[ax][k] = div_nq_ff[TW][ax][TW-1:32] * div_ray_ff[TW].ad[J];

         assign prod = {m1_ph_ff[ax][k], 32'd0} + {{FRAC_BITS{1'b0}}, m1_pl_ff[ax][k]};
         assign m2_ovf_in[ax][k] = |prod[PROD_W-1:64];
         assign m2_off_in[ax][k] = prod[63:FRAC_BITS];

         assign mn = 66'($signed(box_min_ff[J]));
         assign mx = 66'($signed(box_max_ff[J]));
         assign pv = m2_ray_ff.d[J][31]
                   ? 66'($signed(m2_ray_ff.o[J])) - $signed({{(66-OFF_W){1'b0}}, m2_off_ff[ax][k]})
                   : 66'($signed(m2_ray_ff.o[J])) + $signed({{(66-OFF_W){1'b0}}, m2_off_ff[ax][k]});
         assign m3_in_box[ax][k] = (pv >= mn) && (pv <= mx) && !m2_ovf_ff[ax][k];
         assign m3_p_in[ax][k]   = pv[31:0];
         assign m3_m_in[ax][k]   = m2_off_ff[ax][k][31:0];

         assign m4_sq_in[ax][k+1] = m3_m_ff[ax][k] * m3_m_ff[ax][k];
      end

      assign m3_ok_in[ax]    = m2_ray_ff.cand[ax] && m3_in_box[ax][0] && m3_in_box[ax][1];
      assign m4_sq_in[ax][0] = m3_ray_ff.a[ax] * m3_ray_ff.a[ax];
      assign m4_len_in[ax]   = m3_ray_ff.ad[ax] * m3_ray_ff.ad[ax];
      assign m5_sum_in[ax]   = {2'b00, m4_sq_ff[ax][0]} + {2'b00, m4_sq_ff[ax][1]}
                             + {2'b00, m4_sq_ff[ax][2]};
      assign m5_acc_in[ax]   = m4_ok_ff[ax]
                             && (m4_ray_ff.unb
                                 || (m5_sum_in[ax] < {2'b00, m4_len_ff[0] + m4_len_ff[1]
                                                             + m4_len_ff[2]}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
         m4_v_ff <= 1'b0;
         m5_v_ff <= 1'b0;
      end else if (en) begin
         m1_v_ff <= div_v_ff[TW];
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
         m4_v_ff <= m3_v_ff;
         m5_v_ff <= m4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ray_ff <= div_ray_ff[TW];
         m1_pl_ff  <= m1_pl_in;
         m1_ph_ff  <= m1_ph_in;
         m2_ray_ff <= m1_ray_ff;
         m2_off_ff <= m2_off_in;
         m2_ovf_ff <= m2_ovf_in;
         m3_ray_ff <= m2_ray_ff;
         m3_p_ff   <= m3_p_in;
         m3_m_ff   <= m3_m_in;
         m3_ok_ff  <= m3_ok_in;
         m4_ray_ff <= m3_ray_ff;
         m4_p_ff   <= m3_p_ff;
         m4_ok_ff  <= m3_ok_ff;
         m4_sq_ff  <= m4_sq_in;
         m4_len_ff <= m4_len_in;
         m5_ray_ff <= m4_ray_ff;
         m5_p_ff   <= m4_p_ff;
         m5_sum_ff <= m5_sum_in;
         m5_acc_ff <= m5_acc_in;
      end
   end

   // first accepted face, set up root and texture division
   logic [2:0][2:0][31:0] cand_pt;

   for (genvar ax = 0; ax < 3; ax++) begin : g_pt
      assign cand_pt[ax][ax] = m5_ray_ff.d[ax][31] ? box_max_ff[ax] : box_min_ff[ax];
      assign cand_pt[ax][(ax + 1) % 3] = m5_p_ff[ax][0];
      assign cand_pt[ax][(ax + 2) % 3] = m5_p_ff[ax][1];
   end

   tail_type tl_ff [SQ_STEPS+1];
   logic     tl_v_ff [SQ_STEPS+1];
   tail_type sel_in;

   function automatic tex_type tex_init(input logic [31:0] p, input logic [31:0] mn,
                                        input logic [31:0] mx);
      tex_type     t;
      logic [32:0] rel;
      logic [32:0] size;
      rel    = {p[31], p} - {mn[31], mn};
      size   = {mx[31], mx} - {mn[31], mn};
      t.r    = {1'b0, rel[31:1]};
      t.nq   = {rel[0], 16'd0};
      t.size = size[31:0];
      t.flat = (size == 33'd0);
      return t;
   endfunction

   always_comb begin
      logic [1:0] sa;
      logic [1:0] bu;
      logic [1:0] bv;
      logic [65:0] sum;
      sa = m5_acc_ff[0] ? AXIS_X : (m5_acc_ff[1] ? AXIS_Y : AXIS_Z);
      bu = tex_u_axis(sa);
      bv = tex_v_axis(sa);
      sum = m5_sum_ff[sa];
      sel_in.hit  = |m5_acc_ff;
      sel_in.code = face_of(sa, m5_ray_ff.d[sa][31]);
      sel_in.pt   = cand_pt[sa];
      sel_in.sat  = |sum[65:62];
      sel_in.x    = sum[61:0];
      sel_in.root = '0;
      sel_in.rem  = '0;
      sel_in.tu   = tex_init(cand_pt[sa][bu], box_min_ff[bu], box_max_ff[bu]);
      sel_in.tv   = tex_init(cand_pt[sa][bv], box_min_ff[bv], box_max_ff[bv]);
   end

   always_ff @(posedge clock) begin
      if (reset) tl_v_ff[0] <= 1'b0;
      else if (en) tl_v_ff[0] <= m5_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) tl_ff[0] <= sel_in;
   end

   function automatic tex_type tex_step(input tex_type t);
      tex_type     n;
      logic [32:0] rs;
      logic        ge;
      rs     = {t.r, t.nq[16]};
      ge     = rs >= {1'b0, t.size};
      n      = t;
      n.r    = ge ? 32'(rs - {1'b0, t.size}) : rs[31:0];
      n.nq   = {t.nq[15:0], ge};
      return n;
   endfunction

   // square root two bits a stage, texture divide in the first stages
   for (genvar s = 1; s <= SQ_STEPS; s++) begin : g_tail
      tail_type t_in;

      always_comb begin
         logic [34:0] rs;
         logic [34:0] trial;
         logic        ge;
         t_in   = tl_ff[s-1];
         rs     = {tl_ff[s-1].rem, tl_ff[s-1].x[61:60]};
         trial  = {2'b00, tl_ff[s-1].root, 2'b01};
         ge     = rs >= trial;
         t_in.rem  = ge ? 33'(rs - trial) : rs[32:0];
         t_in.root = {tl_ff[s-1].root[29:0], ge};
         t_in.x    = {tl_ff[s-1].x[59:0], 2'b00};
         if (s <= TEX_STEPS) begin
            t_in.tu = tex_step(tl_ff[s-1].tu);
            t_in.tv = tex_step(tl_ff[s-1].tv);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) tl_v_ff[s] <= 1'b0;
         else if (en) tl_v_ff[s] <= tl_v_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (en) tl_ff[s] <= t_in;
      end
   end

   // result word, zero on a miss
   always_comb begin
      tail_type    t;
      logic [30:0] distance;
      logic [16:0] tu;
      logic [16:0] tv;
      t        = tl_ff[SQ_STEPS];
      distance = t.sat ? 31'h7FFF_FFFF : t.root;
      tu       = t.tu.flat ? 17'd0 : t.tu.nq;
      tv       = t.tv.flat ? 17'd0 : t.tv.nq;
      if (t.hit) fin_word = {t.code, 1'b1, 7'd0, tv, tu, distance, t.pt};
      else fin_word = '0;
   end

   // output register with skid
   logic take, inc;
   assign take = out_v_ff && rsp_tready;
   assign inc  = en && tl_v_ff[SQ_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else if (take || !out_v_ff) begin
         if (sk_v_ff) begin
            out_v_ff <= 1'b1;
            sk_v_ff  <= 1'b0;
         end else begin
            out_v_ff <= inc;
         end
      end else if (inc) begin
         sk_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take || !out_v_ff) begin
         out_ff <= sk_v_ff ? sk_ff : fin_word;
      end else if (inc) begin
         sk_ff <= fin_word;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff[RSP_W-1:0];
   assign rsp_tuser  = out_ff[RSP_W+RSP_USER_W-1:RSP_W];

endmodule

// ===== tb/sv/tb_ray_box_face_intersect_top.sv =====
// ----------------------------------------------------------------------------
// tb_ray_box_face_intersect_top
// Self-checking bench for the ray against box face unit.
//
// Rays are streamed in with random gaps and results are drained with random
// back-pressure. Each accepted ray is traced against the current box by a
// behavioural tracer; its word, or the table's for a hand-worked row, is queued
// and compared with the result words in order. A short table of rays, most
// hand-worked, runs first. Random phases follow under the reset box, then under
// new boxes: an offset box, the full range, a flat axis, an inverted axis and
// small boxes. Most random rays aim at a point inside the box, the rest are noise.
// ----------------------------------------------------------------------------
module tb_ray_box_face_intersect_top;
   import rbf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 6000;
   localparam int PHASE_RAYS  = 250;
   localparam int DRAIN_WAIT  = 120;
   localparam int LONG_HOLD   = 1200;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct packed {
      logic        hit;
      logic [2:0]  face;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [30:0] distance;
      logic [16:0] tu;
      logic [16:0] tv;
   } hit_word_type;

   typedef struct {
      logic [31:0]  o [3];
      logic [31:0]  d [3];
      logic         unb;
      bit           typed;
      hit_word_type want;
   } ray_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [31:0]           csr_data = '0;

   longint       box_lo [3];
   longint       box_hi [3];
   hit_word_type pending_hits [$];
   int           mismatches = 0;
   int           rays_sent = 0;
   int           words_seen = 0;
   int           face_tally [7];
   int           idle_cycles = 0;
   bit           hold_long = 1'b0;
   bit           steady = 1'b0;

   ray_box_face_intersect_top uut (.*);

   always #6 clock = ~clock;

   function automatic logic [63:0] mag(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= x) r = c;
      end
      return r;
   endfunction

   function automatic logic [16:0] tex_of(input longint p, input int ax);
      longint span;
      longint rel;
      span = box_hi[ax] - box_lo[ax];
      rel  = p - box_lo[ax];
      if (span <= 0 || rel < 0) return '0;
      return 17'((64'(rel) << 16) / 64'(span));
   endfunction

   function automatic bit cross_face(input int k, input longint o [3], input longint d [3],
                                     input logic unb, output hit_word_type w);
      int           ax;
      bit           upper;
      longint       plane;
      longint       p [3];
      logic [63:0]  t;
      logic [127:0] prod;
      logic [127:0] sq_sum;
      logic [63:0]  reach2;
      logic [63:0]  distance;
      int           ub;
      int           vb;
      ax    = k >> 1;
      upper = (k % 2) == 0;
      plane = upper ? box_hi[ax] : box_lo[ax];
      w     = '0;
      if (upper && !(d[ax] < 0 && plane < o[ax])) return 0;
      if (!upper && !(d[ax] > 0 && plane > o[ax])) return 0;
      t = (mag(plane - o[ax]) << FRAC_BITS) / mag(d[ax]);
      p[ax] = plane;
      for (int j = 0; j < 3; j++) begin
         if (j != ax) begin
            prod = 128'(t) * 128'(mag(d[j]));
            if (prod[127:64] != 0) return 0;
            prod = prod >> FRAC_BITS;
            p[j] = d[j] < 0 ? o[j] - longint'(prod[63:0]) : o[j] + longint'(prod[63:0]);
            if (p[j] < box_lo[j] || p[j] > box_hi[j]) return 0;
         end
      end
      sq_sum = 0;
      reach2 = 0;
      for (int j = 0; j < 3; j++) begin
         sq_sum += 128'(mag(p[j] - o[j])) * 128'(mag(p[j] - o[j]));
         reach2 += mag(d[j]) * mag(d[j]);
      end
      if (!unb && !(sq_sum[127:64] == 0 && sq_sum[63:0] < reach2)) return 0;
      if (sq_sum[127:64] != 0 || sq_sum[63:0] >= (64'd1 << 62)) distance = 64'h7FFF_FFFF;
      else distance = int_sqrt(sq_sum[63:0]);
      ub = (ax == 0) ? 2 : 0;
      vb = (ax == 1) ? 2 : 1;
      w.hit      = 1'b1;
      w.face     = face_of(2'(ax), upper);
      w.px       = 32'(p[0]);
      w.py       = 32'(p[1]);
      w.pz       = 32'(p[2]);
      w.distance = 31'(distance);
      w.tu       = tex_of(p[ub], ub);
      w.tv       = tex_of(p[vb], vb);
      return 1;
   endfunction

   function automatic hit_word_type trace_ray(input logic [31:0] ro [3],
                                              input logic [31:0] rd [3], input logic unb);
      longint       o [3];
      longint       d [3];
      hit_word_type w;
      for (int i = 0; i < 3; i++) begin
         o[i] = longint'(signed'(ro[i]));
         d[i] = longint'(signed'(rd[i]));
      end
      for (int k = 0; k < 6; k++)
         if (cross_face(k, o, d, unb, w)) return w;
      return '0;
   endfunction

   function automatic void compare_hit(input hit_word_type want, input hit_word_type got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("MISMATCH word %0d: hit %0b/%0b face %0d/%0d", words_seen,
                     want.hit, got.hit, want.face, got.face);
            $display("  point exp %h %h %h got %h %h %h", want.px, want.py, want.pz,
                     got.px, got.py, got.pz);
            $display("  dist exp %h got %h  tex exp %h %h got %h %h", want.distance,
                     got.distance, want.tu, want.tv, got.tu, got.tv);
         end
      end
   endfunction

   // checker and watchdog
   always @(posedge clock) begin
      hit_word_type got;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], rsp_tuser[3:1], rsp_tdata[31:0], rsp_tdata[63:32],
                   rsp_tdata[95:64], rsp_tdata[126:96], rsp_tdata[143:127],
                   rsp_tdata[160:144]};
            if (pending_hits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word %0d: exp none got %h", words_seen, got);
            end else begin
               compare_hit(pending_hits.pop_front(), got);
            end
            face_tally[got.face > 6 ? 0 : got.face]++;
            words_seen++;
         end
      end
   end

   // result drain
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end else begin
            n = steady ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic write_box(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx < 3) box_lo[idx] = longint'(signed'(val));
      else if (idx < 6) box_hi[idx - 3] = longint'(signed'(val));
      @(posedge clock);
   endtask

   task automatic drain_and_wait();
      req_tvalid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic load_box(input logic [31:0] lx, ly, lz, hx, hy, hz);
      drain_and_wait();
      write_box(CSR_MIN_X, lx);
      write_box(CSR_MIN_Y, ly);
      write_box(CSR_MIN_Z, lz);
      write_box(CSR_MAX_X, hx);
      write_box(CSR_MAX_Y, hy);
      write_box(CSR_MAX_Z, hz);
   endtask

   task automatic send_ray(input logic [31:0] o [3], input logic [31:0] d [3],
                           input logic unb, input bit typed, input hit_word_type want);
      int           gap;
      hit_word_type traced;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {d[2], d[1], d[0], o[2], o[1], o[0]};
      req_tuser  <= unb;
      do @(posedge clock); while (!req_tready);
      traced = trace_ray(o, d, unb);
      if (typed && traced !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tracer disagrees with table row %0d: exp %h got %h", rays_sent,
                     want, traced);
      end
      pending_hits.push_back(typed ? want : traced);
      rays_sent++;
   endtask

   function automatic logic [31:0] rand_near(input int ax);
      longint span;
      span = box_hi[ax] - box_lo[ax];
      if (span <= 0) return 32'(box_lo[ax]);
      return 32'(box_lo[ax] + longint'({$urandom, $urandom} % 64'(span + 1)));
   endfunction

   task automatic random_rays(input int count);
      logic [31:0] o [3];
      logic [31:0] d [3];
      logic [31:0] aim;
      longint      off;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < 3; i++) begin
               o[i] = $urandom;
               d[i] = $urandom;
            end
         end else begin
            for (int i = 0; i < 3; i++) begin
               aim  = rand_near(i);
               off  = longint'($urandom_range(0, 1 << $urandom_range(0, 24)));
               if ($urandom_range(0, 1)) off = -off;
               o[i] = 32'(longint'(signed'(aim)) + off);
               d[i] = 32'(-off * longint'($urandom_range(1, 2)));
            end
         end
         send_ray(o, d, $urandom_range(0, 1), 1'b0, '0);
      end
      steady = 1'b0;
   endtask

   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] HALF = 32'h0000_8000;
   localparam logic [31:0] QTR  = 32'h0000_4000;
   localparam logic [31:0] TQ   = 32'h0000_C000;

   ray_row_type ray_table [$];

   function automatic void add_row(input logic [31:0] ox, oy, oz, dx, dy, dz,
                                   input logic unb, input bit typed,
                                   input hit_word_type want);
      ray_row_type r;
      r.o = '{ox, oy, oz};
      r.d = '{dx, dy, dz};
      r.unb = unb;
      r.typed = typed;
      r.want = want;
      ray_table.push_back(r);
   endfunction

   initial begin
      for (int i = 0; i < 3; i++) begin
         box_lo[i] = longint'(signed'(BOX_MIN_RESET));
         box_hi[i] = longint'(signed'(BOX_MAX_RESET));
      end
      add_row(HALF, HALF, HALF, 0, 0, 0, 0, 1, '0);
      add_row(2 * ONE, HALF, HALF, -4 * ONE, 0, 0, 0, 1,
              '{1, FACE_POS_X, ONE, HALF, HALF, 31'(ONE), 17'(HALF), 17'(HALF)});
      add_row(2 * ONE, HALF, HALF, -HALF, 0, 0, 0, 1, '0);
      add_row(2 * ONE, HALF, HALF, -HALF, 0, 0, 1, 1,
              '{1, FACE_POS_X, ONE, HALF, HALF, 31'(ONE), 17'(HALF), 17'(HALF)});
      add_row(-ONE, HALF, HALF, 4 * ONE, 0, 0, 0, 1,
              '{1, FACE_NEG_X, 0, HALF, HALF, 31'(ONE), 17'(HALF), 17'(HALF)});
      add_row(QTR, 2 * ONE, TQ, 0, -4 * ONE, 0, 0, 1,
              '{1, FACE_POS_Y, QTR, ONE, TQ, 31'(ONE), 17'(QTR), 17'(TQ)});
      add_row(HALF, -ONE, QTR, 0, 3 * ONE, 0, 0, 0, '0);
      add_row(QTR, TQ, 3 * ONE, HALF, -HALF, -5 * ONE, 0, 0, '0);
      add_row(HALF, HALF, -ONE, 0, 0, 4 * ONE, 0, 1,
              '{1, FACE_NEG_Z, HALF, HALF, 0, 31'(ONE), 17'(HALF), 17'(HALF)});
      add_row(2 * ONE, ONE, HALF, -ONE, 0, 0, 0, 1, '0);
      add_row(2 * ONE, ONE, HALF, -ONE, 0, 0, 1, 1,
              '{1, FACE_POS_X, ONE, ONE, HALF, 31'(ONE), 17'(HALF), 17'h10000});
      add_row(HALF, HALF, HALF, ONE, ONE, ONE, 1, 1, '0);
      add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, '0);
      add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, '0);
      add_row(32'h8000_0000, HALF, HALF, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 0, 0, '0);
      add_row(3 * ONE, 2 * ONE, -2 * ONE, -ONE, -ONE, ONE, 0, 0, '0);
      add_row(HALF, HALF, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, '0);
      add_row(HALF, HALF, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 1, 0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (ray_table[i])
         send_ray(ray_table[i].o, ray_table[i].d, ray_table[i].unb,
                  ray_table[i].typed, ray_table[i].want);
      random_rays(PHASE_RAYS / 2);
      hold_long = 1'b1;
      random_rays(PHASE_RAYS / 2);

      load_box(-3 * ONE, -ONE, 0, 2 * ONE, 5 * ONE, ONE);
      write_box(CSR_SPARE_A, $urandom);
      write_box(CSR_SPARE_B, $urandom);
      random_rays(PHASE_RAYS);

      load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      random_rays(PHASE_RAYS);

      load_box(HALF, -ONE, -2 * ONE, HALF, ONE, 2 * ONE);
      random_rays(PHASE_RAYS);

      load_box(0, ONE, 0, ONE, -ONE, ONE);
      random_rays(PHASE_RAYS / 2);

      for (int ph = 0; ph < 3; ph++) begin
         logic [31:0] lo [3];
         for (int i = 0; i < 3; i++) lo[i] = $urandom_range(0, 1 << 22) - (1 << 21);
         load_box(lo[0], lo[1], lo[2], lo[0] + $urandom_range(1, 1 << 20),
                  lo[1] + $urandom_range(1, 1 << 20), lo[2] + $urandom_range(1, 1 << 20));
         random_rays(PHASE_RAYS);
      end

      drain_and_wait();
      $display("rays %0d, words %0d; faces +X %0d -X %0d +Y %0d -Y %0d +Z %0d -Z %0d, miss %0d",
               rays_sent, words_seen, face_tally[1], face_tally[2], face_tally[3],
               face_tally[4], face_tally[5], face_tally[6], face_tally[0]);
      $display("boxes: reset, offset, full range, flat, inverted, random; %0d mismatches",
               mismatches);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/rbf_pkg.sv
design/ray_box_face_intersect_top.sv
tb/sv/tb_ray_box_face_intersect_top.sv
